// File: hw/rtl/trapezoid_velocity_profile_step_macros.svh
// assertion macros for the trapezoid velocity profile block
// used by the checker module, no other dependencies
`ifndef TRAPEZOID_VELOCITY_PROFILE_STEP_MACROS_SVH
`define TRAPEZOID_VELOCITY_PROFILE_STEP_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvp assertion failed");

// next-cycle implication under synchronous active-low reset
`define TVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvp assertion failed");

`endif

// File: hw/rtl/tvp_pkg.sv
// shared widths and codes for the trapezoid velocity profile block
// no dependencies
`default_nettype none
package tvp_pkg;
    localparam int POS_W   = 48;
    localparam int VEL_W   = 32;
    localparam int ACC_W   = 32;
    localparam int PHASE_W = 4;
    localparam int ADDR_W  = 4;

    localparam logic [PHASE_W-1:0] PH_STOP       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_FWD_ACC    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_FWD_DEC    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_FWD_STEADY = 4'd3;
    localparam logic [PHASE_W-1:0] PH_REV_ACC    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_REV_DEC    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_REV_STEADY = 4'd6;
    localparam logic [PHASE_W-1:0] PH_FINISHED   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ERROR      = 4'd8;

    localparam logic [1:0] REG_MAX_VEL = 2'd0;
    localparam logic [1:0] REG_MAX_ACC = 2'd1;
    localparam logic [1:0] REG_TICK    = 2'd2;
    localparam logic [1:0] REG_TOL     = 2'd3;
endpackage
`default_nettype wire

// File: hw/rtl/trapezoid_velocity_profile_step.sv
// top level of the trapezoid velocity profile block
// depends on tvp_pkg
`default_nettype none
// One item per servo tick: target position, end velocity, direction flag in;
// new position, velocity, acceleration and phase out. Once an item is taken,
// a small sequencer drives one shared 32x32 unsigned multiplier six times
// (step size dv, the two halves of distance times 2a, end velocity squared,
// velocity squared, and the position step), then picks the phase,
// integrates and runs the finish checks before the result shows on o_valid.
// o_stall stays high while an item is in work, so no new item is taken until
// the last has gone to the result register; that register lets the next item enter
// while a result still waits. Registers live on an APB port at byte
// addresses 0x0 max_velocity, 0x4 max_acceleration, 0x8 tick_period,
// 0xc finish_tolerance; write them only while the block is idle.
module trapezoid_velocity_profile_step (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [tvp_pkg::POS_W-1:0]  i_target_position,
    input  wire logic signed [tvp_pkg::VEL_W-1:0]  i_end_velocity,
    input  wire logic                              i_reverse_move,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [tvp_pkg::POS_W-1:0]       o_position_out,
    output logic signed [tvp_pkg::VEL_W-1:0]       o_velocity_out,
    output logic signed [tvp_pkg::ACC_W-1:0]       o_acceleration_out,
    output logic [tvp_pkg::PHASE_W-1:0]            o_phase,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tvp_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    // sequencer codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MDV  = 4'd1;  // amax * tick
    localparam logic [3:0] ST_MD0  = 4'd2;  // dmag low word * 2a
    localparam logic [3:0] ST_MD1  = 4'd3;  // dmag high part * 2a
    localparam logic [3:0] ST_MEV  = 4'd4;  // ve squared
    localparam logic [3:0] ST_MV   = 4'd5;  // v squared
    localparam logic [3:0] ST_PH   = 4'd6;  // compare, pick phase, new velocity
    localparam logic [3:0] ST_MP   = 4'd7;  // |v| * tick
    localparam logic [3:0] ST_POS  = 4'd8;  // position integrate
    localparam logic [3:0] ST_FIN  = 4'd9;  // finish checks, result out

    localparam logic signed [33:0] VEL_MAX34 = $signed({3'b000, {31{1'b1}}});
    localparam logic signed [33:0] VEL_MIN34 = $signed({3'b111, {31{1'b0}}});
    localparam logic signed [49:0] POS_MAX50 = $signed({3'b000, {47{1'b1}}});
    localparam logic signed [49:0] POS_MIN50 = $signed({3'b111, {47{1'b0}}});

    // configuration
    logic [30:0] r_max_vel, r_max_acc, r_tol;
    logic [31:0] r_tick;

    // motion state
    logic signed [tvp_pkg::POS_W-1:0] r_pos;
    logic signed [tvp_pkg::VEL_W-1:0] r_vel;
    logic signed [tvp_pkg::ACC_W-1:0] r_acc;

    // per-item working registers
    logic [3:0]                          r_state;
    logic signed [tvp_pkg::POS_W-1:0]    r_tar;
    logic signed [tvp_pkg::VEL_W-1:0]    r_ev;
    logic                                r_rev, r_fwd;
    logic [47:0]                         r_dmag;
    logic [31:0]                         r_evmag, r_vmag;
    logic [30:0]                         r_dv;
    logic [80:0]                         r_sum;
    logic [63:0]                         r_prod;
    logic [tvp_pkg::PHASE_W-1:0]         r_phase;
    logic signed [tvp_pkg::VEL_W-1:0]    r_nvel;
    logic signed [tvp_pkg::ACC_W-1:0]    r_nacc;
    logic signed [tvp_pkg::POS_W-1:0]    r_npos;

    // result register
    logic                                r_o_valid;
    logic signed [tvp_pkg::POS_W-1:0]    r_o_pos;
    logic signed [tvp_pkg::VEL_W-1:0]    r_o_vel;
    logic signed [tvp_pkg::ACC_W-1:0]    r_o_acc;
    logic [tvp_pkg::PHASE_W-1:0]         r_o_phase;

    logic in_take, cfg_wr, out_load;

    assign pready  = 1'b1;
    assign o_stall = (r_state != ST_IDLE);
    assign in_take = i_valid && !o_stall;
    assign cfg_wr  = psel && penable && pwrite;

    assign o_valid            = r_o_valid;
    assign o_position_out     = r_o_pos;
    assign o_velocity_out     = r_o_vel;
    assign o_acceleration_out = r_o_acc;
    assign o_phase            = r_o_phase;

    // register readback
    always_comb begin
        case (paddr[3:2])
            tvp_pkg::REG_MAX_VEL: prdata = {1'b0, r_max_vel};
            tvp_pkg::REG_MAX_ACC: prdata = {1'b0, r_max_acc};
            tvp_pkg::REG_TICK:    prdata = r_tick;
            tvp_pkg::REG_TOL:     prdata = {1'b0, r_tol};
            default:              prdata = 32'd0;
        endcase
    end

    // item intake: direction, distance to go, magnitudes
    logic signed [tvp_pkg::VEL_W-1:0] n_ev;
    logic signed [48:0]               n_diff;
    logic                             n_fwd;
    logic [47:0]                      n_dmag;
    logic [31:0]                      n_evmag, n_vmag;
    always_comb begin
        n_ev    = (i_reverse_move && i_end_velocity > 0) ? -i_end_velocity : i_end_velocity;
        n_evmag = n_ev[31] ? 32'(-n_ev) : 32'(n_ev);
        n_vmag  = r_vel[31] ? 32'(-r_vel) : 32'(r_vel);
        n_diff  = 49'(i_target_position) - 49'(r_pos);
        n_fwd   = n_diff > 0;
        n_dmag  = n_fwd ? n_diff[47:0] : 48'(-n_diff);
    end

    // the shared multiplier, operands picked by the sequencer
    logic [31:0] m_a, m_b;
    logic [63:0] n_prod;
    always_comb begin
        case (r_state)
            ST_MDV:  begin m_a = {1'b0, r_max_acc};        m_b = r_tick;            end
            ST_MD0:  begin m_a = r_dmag[31:0];             m_b = {r_max_acc, 1'b0}; end
            ST_MD1:  begin m_a = {16'd0, r_dmag[47:32]};   m_b = {r_max_acc, 1'b0}; end
            ST_MEV:  begin m_a = r_evmag;                  m_b = r_evmag;           end
            ST_MV:   begin m_a = r_vmag;                   m_b = r_vmag;            end
            ST_MP:   begin
                m_a = r_nvel[31] ? 32'(-r_nvel) : 32'(r_nvel);
                m_b = r_tick;
            end
            default: begin m_a = 32'd0;                    m_b = 32'd0;             end
        endcase
        n_prod = m_a * m_b;
    end

    // phase choice and velocity update; r_sum is |dtg|*2a + ve^2, r_prod is v^2
    logic [tvp_pkg::PHASE_W-1:0]      n_phase;
    logic signed [33:0]               v34, d34, vmx34, t34, tmag;
    logic signed [tvp_pkg::ACC_W-1:0] a_pos, a_new;
    logic signed [tvp_pkg::VEL_W-1:0] n_vel_ph;
    logic                             gt, lt;
    always_comb begin
        gt    = r_sum > {17'd0, r_prod};
        lt    = r_sum < {17'd0, r_prod};
        v34   = 34'(r_vel);
        d34   = $signed({3'b000, r_dv});
        vmx34 = $signed({3'b000, r_max_vel});
        a_pos = $signed({1'b0, r_max_acc});

        if (r_vmag > {1'b0, r_max_vel}) begin
            n_phase = tvp_pkg::PH_STOP;
        end else if (r_dmag == 48'd0) begin
            n_phase = tvp_pkg::PH_ERROR;
        end else if ((!r_fwd && r_vel > 0) || (r_fwd && r_vel < 0)) begin
            n_phase = tvp_pkg::PH_STOP;
        end else if (gt && r_vmag < {1'b0, r_max_vel}) begin
            n_phase = r_fwd ? tvp_pkg::PH_FWD_ACC : tvp_pkg::PH_REV_ACC;
        end else if (lt) begin
            n_phase = r_fwd ? tvp_pkg::PH_FWD_DEC : tvp_pkg::PH_REV_DEC;
        end else if (r_vmag == {1'b0, r_max_vel}) begin
            n_phase = r_fwd ? tvp_pkg::PH_FWD_STEADY : tvp_pkg::PH_REV_STEADY;
        end else begin
            n_phase = tvp_pkg::PH_ERROR;
        end

        t34   = v34;
        a_new = r_acc;
        case (n_phase)
            tvp_pkg::PH_STOP: begin
                if (r_vel > 0) begin
                    a_new = -a_pos;
                    t34   = v34 - d34;
                    if (t34 < 0) t34 = '0;
                end else begin
                    a_new = a_pos;
                    t34   = v34 + d34;
                    if (t34 > 0) t34 = '0;
                end
            end
            tvp_pkg::PH_FWD_ACC: begin
                a_new = a_pos;
                t34   = v34 + d34;
                if (t34 > vmx34) t34 = vmx34;
            end
            tvp_pkg::PH_FWD_DEC: begin
                a_new = -a_pos;
                t34   = v34 - d34;
                if (t34 < 0) t34 = '0;
            end
            tvp_pkg::PH_REV_ACC: begin
                a_new = -a_pos;
                t34   = v34 - d34;
                if (t34 < -vmx34) t34 = -vmx34;
            end
            tvp_pkg::PH_REV_DEC: begin
                a_new = a_pos;
                t34   = v34 + d34;
                if (t34 > 0) t34 = '0;
            end
            tvp_pkg::PH_FWD_STEADY, tvp_pkg::PH_REV_STEADY: begin
                a_new = '0;
            end
            default: begin
                t34   = v34;
                a_new = r_acc;
            end
        endcase

        // stop: below one step counts as standing still
        tmag = (t34 < 0) ? -t34 : t34;
        if (n_phase == tvp_pkg::PH_STOP && tmag < d34) begin
            t34   = '0;
            a_new = '0;
        end

        if (t34 > VEL_MAX34)      n_vel_ph = VEL_MAX34[31:0];
        else if (t34 < VEL_MIN34) n_vel_ph = VEL_MIN34[31:0];
        else                      n_vel_ph = t34[31:0];
    end

    // position step: floor(v * tick / 2^32), rounding toward minus infinity
    logic signed [33:0] dp_mag, dp;
    logic signed [49:0] psum;
    logic signed [tvp_pkg::POS_W-1:0] n_npos;
    always_comb begin
        dp_mag = $signed({2'b00, r_prod[63:32]}) + $signed({33'd0, |r_prod[31:0]});
        if (r_nvel < 0) dp = -dp_mag;
        else            dp = $signed({2'b00, r_prod[63:32]});
        psum = 50'(r_pos) + 50'(dp);
        if (r_phase == tvp_pkg::PH_ERROR) n_npos = r_pos;
        else if (psum > POS_MAX50)        n_npos = POS_MAX50[47:0];
        else if (psum < POS_MIN50)        n_npos = POS_MIN50[47:0];
        else                              n_npos = psum[47:0];
    end

    // finish checks: pass-through with nonzero end velocity, or stop at target
    logic signed [48:0]               fd;
    logic                             ahead;
    logic [48:0]                      rem;
    logic signed [tvp_pkg::POS_W-1:0] f_pos;
    logic signed [tvp_pkg::VEL_W-1:0] f_vel;
    logic signed [tvp_pkg::ACC_W-1:0] f_acc;
    logic [tvp_pkg::PHASE_W-1:0]      f_phase;
    always_comb begin
        fd      = 49'(r_tar) - 49'(r_npos);
        ahead   = fd > 0;
        rem     = ahead ? 49'(fd) : 49'(-fd);
        f_pos   = r_npos;
        f_vel   = r_nvel;
        f_acc   = r_nacc;
        f_phase = r_phase;
        if (r_nvel > 0 && r_ev > 0 && fd < 0 && !r_rev) begin
            f_phase = tvp_pkg::PH_FINISHED;
        end else if (r_nvel < 0 && r_ev < 0 && fd > 0 && r_rev) begin
            f_phase = tvp_pkg::PH_FINISHED;
        end else if (r_ev == 0 && ((!r_rev && (!ahead || rem <= {18'd0, r_tol})) ||
                                   (r_rev && rem <= {18'd0, r_tol}))) begin
            f_pos   = r_tar;
            f_vel   = '0;
            f_acc   = '0;
            f_phase = tvp_pkg::PH_FINISHED;
        end
    end

    // result may load when the output slot is empty or being taken
    assign out_load = (r_state == ST_FIN) && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_max_vel <= 31'd0;
            r_max_acc <= 31'd65536;
            r_tick    <= 32'd4294967;
            r_tol     <= 31'd0;
            r_pos     <= '0;
            r_vel     <= '0;
            r_acc     <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    tvp_pkg::REG_MAX_VEL: r_max_vel <= pwdata[30:0];
                    tvp_pkg::REG_MAX_ACC: r_max_acc <= pwdata[30:0];
                    tvp_pkg::REG_TICK:    r_tick    <= pwdata;
                    tvp_pkg::REG_TOL:     r_tol     <= pwdata[30:0];
                    default:              r_tick    <= r_tick;
                endcase
            end

            // output slot: filled by a finished item, emptied when taken
            if (out_load)      r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_tar   <= i_target_position;
                        r_ev    <= n_ev;
                        r_rev   <= i_reverse_move;
                        r_fwd   <= n_fwd;
                        r_dmag  <= n_dmag;
                        r_evmag <= n_evmag;
                        r_vmag  <= n_vmag;
                        r_state <= ST_MDV;
                    end
                end
                ST_MDV: r_state <= ST_MD0;
                ST_MD0: begin
                    r_dv    <= r_prod[62:32];
                    r_state <= ST_MD1;
                end
                ST_MD1: begin
                    r_sum   <= {17'd0, r_prod};
                    r_state <= ST_MEV;
                end
                ST_MEV: begin
                    r_sum   <= r_sum + {r_prod[48:0], 32'd0};
                    r_state <= ST_MV;
                end
                ST_MV: begin
                    r_sum   <= r_sum + {17'd0, r_prod};
                    r_state <= ST_PH;
                end
                ST_PH: begin
                    r_phase <= n_phase;
                    r_nvel  <= n_vel_ph;
                    r_nacc  <= a_new;
                    r_state <= ST_MP;
                end
                ST_MP: r_state <= ST_POS;
                ST_POS: begin
                    r_npos  <= n_npos;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_pos     <= f_pos;
                        r_vel     <= f_vel;
                        r_acc     <= f_acc;
                        r_o_pos   <= f_pos;
                        r_o_vel   <= f_vel;
                        r_o_acc   <= f_acc;
                        r_o_phase <= f_phase;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/tvp_checker.sv
// port-level checks for the trapezoid velocity profile block, bound to the top
// depends on tvp_pkg and the macros header
`default_nettype none
`include "trapezoid_velocity_profile_step_macros.svh"
module tvp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic signed [tvp_pkg::POS_W-1:0]  o_position_out,
    input wire logic signed [tvp_pkg::ACC_W-1:0]  o_acceleration_out,
    input wire logic [tvp_pkg::PHASE_W-1:0]       o_phase
);
    // a held result keeps its payload
    `TVP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_position_out) && $stable(o_phase))
    // one item at a time: busy right after an accept
    `TVP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // phase code in range
    `TVP_ASSERT_NOW(a_phase_rng, i_clk, i_rst_n, o_valid, o_phase <= tvp_pkg::PH_ERROR)
    // cruising applies no acceleration
    `TVP_ASSERT_NOW(a_steady_acc, i_clk, i_rst_n,
        o_valid && (o_phase == tvp_pkg::PH_FWD_STEADY || o_phase == tvp_pkg::PH_REV_STEADY),
        o_acceleration_out == 0)
endmodule

bind trapezoid_velocity_profile_step tvp_checker u_tvp_checker (.*);
`default_nettype wire
